/* hw/rtl/fpv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_pkg: shared types, constants and helpers
// Request formats, fixed-point constants and rounding/saturation functions.
// ----------------------------------------------------------------------------
package fpv_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [15:0] STALE_LIMIT_MS = 16'd1000;

  localparam logic [31:0] Q_ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] Q_HALF  = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic [31:0] KP_Q    = 32'(((64'd18 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] KD_Q    = Q_HALF;
  localparam logic [31:0] CUT_Q   = 32'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] ALPHA_Q = 32'(((64'd7 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] BETA_Q  = Q_ONE - ALPHA_Q;
  localparam logic [31:0] DEADBAND_Q = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [63:0] DB_SQ   = 64'(DEADBAND_Q) * 64'(DEADBAND_Q);
  localparam logic [31:0] UNC_LO_Q = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] UNC_HI_Q = 32'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);

  // Rounded-up 2^34 / 5: bits 63:34 of y times this give y / 5 for any 32-bit y.
  localparam logic [31:0] DIV5_RECIP = 32'hcccccccd;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic [65:0] HALF66 = 66'(Q_HALF);

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_vx;
    logic signed [31:0] own_vy;
    logic [31:0]        position_variance;
    logic signed [31:0] peer_x;
    logic signed [31:0] peer_y;
    logic signed [31:0] peer_vx;
    logic signed [31:0] peer_vy;
    logic               peer_present;
    logic [15:0]        peer_age_ms;
  } in_t;

  typedef struct packed {
    logic signed [31:0] cmd_vx;
    logic signed [31:0] cmd_vy;
    logic               cmd_valid;
  } out_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Shift right by the fraction, rounding to nearest with ties away from zero.
  function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + HALF66) >> FRAC_BITS;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/formation_follow_pd_velocity.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formation_follow_pd_velocity: formation follower velocity controller
// PD correction towards the neighbour plus offset, magnitude limits,
// feedforward and a low-pass filter, under a sequencer sharing one multiplier.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   in       | input     | in_valid/in_ready  | in_data (fpv_pkg::in_t)
//   out      | output    | out_valid/out_ready| out_data (fpv_pkg::out_t)
//   config   | input     | APB write/read     | pwdata/prdata, paddr[4:2]
//
// An inactive or stale request goes from the check straight to the output. A full
// request runs every step, with the cut steps added inside the deadband, and each of
// the two magnitude limits that engages adds one run of the 32-step square root and two of the divider.
// Reset is synchronous and clears control state and the filter state.
// A new request is taken only when the sequencer is idle; a finished result
// waits in the output register while the next request is taken.
module formation_follow_pd_velocity (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fpv_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fpv_pkg::out_t   out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_OWN_OFS_X = 3'd1;
  localparam logic [2:0] REG_OWN_OFS_Y = 3'd2;
  localparam logic [2:0] REG_PEER_OFS_X = 3'd3;
  localparam logic [2:0] REG_PEER_OFS_Y = 3'd4;
  localparam logic [2:0] REG_SPEED     = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_UNC, S_KP_ISS, S_KP, S_KD, S_PX, S_DX, S_PY, S_DY,
    S_EX2, S_EY2, S_CUTX, S_CUTY, S_LSQ, S_LSQX, S_LSQY, S_LCMP, S_LSQRT,
    S_LMX, S_LDX, S_LWX, S_LMY, S_LDY, S_LWY, S_LEND, S_FLX, S_FLX2, S_FLX3,
    S_FLY2, S_FLY3, S_OUT
  } state_t;

  state_t state;

  logic               t_en;
  logic signed [31:0] own_ofs_x, own_ofs_y, peer_ofs_x, peer_ofs_y;
  logic [30:0]        speed;

  fpv_pkg::in_t       inp;
  logic signed [31:0] ex, ey, dvx, dvy, vec_x, vec_y, sm_x, sm_y;
  logic [31:0]        unc, factor, kp, kd, lim2, mroot;
  logic [63:0]        sumsq;
  logic signed [65:0] acc;
  logic               pass, res_ok;

  logic [31:0]        mul_a, mul_b;
  logic               mul_neg;
  logic signed [64:0] prod;

  logic               sq_start, sq_done;
  logic [63:0]        sq_arg;
  logic [31:0]        sq_root;
  logic               dv_start, dv_done;
  logic [63:0]        dv_num;
  logic [31:0]        dv_den, dv_quot;

  logic [33:0]        lim1_w;
  logic [31:0]        lim1, lim;
  logic [34:0]        unc_d;
  logic [31:0]        factor_c;
  logic               cfg_wr;

  fpv_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .neg(mul_neg), .prod(prod));

  fpv_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .arg(sq_arg),
    .done(sq_done), .root(sq_root)
  );

  fpv_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;

  assign lim1_w = 34'(speed) * 34'd3 + 34'd1;
  assign lim1   = lim1_w[32:1];
  assign lim    = pass ? lim2 : lim1;

  // Uncertainty factor: one, then a linear fall, floored at one half.
  always_comb begin
    unc_d = 35'(unc - fpv_pkg::UNC_LO_Q) * 35'd5;
    if (unc > fpv_pkg::UNC_HI_Q) begin
      factor_c = fpv_pkg::Q_HALF;
    end else if (unc > fpv_pkg::UNC_LO_Q) begin
      factor_c = (unc_d >= 35'(fpv_pkg::Q_ONE - fpv_pkg::Q_HALF)) ?
                 fpv_pkg::Q_HALF : 32'(35'(fpv_pkg::Q_ONE) - unc_d);
    end else begin
      factor_c = fpv_pkg::Q_ONE;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:     prdata = {31'b0, t_en};
      REG_OWN_OFS_X:  prdata = own_ofs_x;
      REG_OWN_OFS_Y:  prdata = own_ofs_y;
      REG_PEER_OFS_X: prdata = peer_ofs_x;
      REG_PEER_OFS_Y: prdata = peer_ofs_y;
      REG_SPEED:      prdata = {1'b0, speed};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state)
      // 1.2 times the speed is speed + (speed + 2) / 5, the fifth by reciprocal.
      S_UNC:    begin mul_a = fpv_pkg::DIV5_RECIP; mul_b = 32'(speed) + 32'd2; end
      S_KP_ISS: begin mul_a = fpv_pkg::KP_Q; mul_b = factor_c; end
      S_KP:     begin mul_a = fpv_pkg::KD_Q; mul_b = factor; end
      S_KD:     begin mul_a = kp; mul_b = fpv_pkg::abs32(ex); mul_neg = ex[31]; end
      S_PX:     begin mul_a = kd; mul_b = fpv_pkg::abs32(dvx); mul_neg = dvx[31]; end
      S_DX:     begin mul_a = kp; mul_b = fpv_pkg::abs32(ey); mul_neg = ey[31]; end
      S_PY:     begin mul_a = kd; mul_b = fpv_pkg::abs32(dvy); mul_neg = dvy[31]; end
      S_DY:     begin mul_a = fpv_pkg::abs32(ex); mul_b = fpv_pkg::abs32(ex); end
      S_EX2:    begin mul_a = fpv_pkg::abs32(ey); mul_b = fpv_pkg::abs32(ey); end
      S_EY2:    begin
        mul_a = fpv_pkg::CUT_Q; mul_b = fpv_pkg::abs32(vec_x); mul_neg = vec_x[31];
      end
      S_CUTX:   begin
        mul_a = fpv_pkg::CUT_Q; mul_b = fpv_pkg::abs32(vec_y); mul_neg = vec_y[31];
      end
      S_LSQ:    begin mul_a = fpv_pkg::abs32(vec_x); mul_b = fpv_pkg::abs32(vec_x); end
      S_LSQX:   begin mul_a = fpv_pkg::abs32(vec_y); mul_b = fpv_pkg::abs32(vec_y); end
      S_LSQY:   begin mul_a = lim; mul_b = lim; end
      S_LMX:    begin mul_a = fpv_pkg::abs32(vec_x); mul_b = lim; end
      S_LMY:    begin mul_a = fpv_pkg::abs32(vec_y); mul_b = lim; end
      S_FLX:    begin
        mul_a = fpv_pkg::ALPHA_Q; mul_b = fpv_pkg::abs32(vec_x); mul_neg = vec_x[31];
      end
      S_FLX2:   begin
        mul_a = fpv_pkg::BETA_Q; mul_b = fpv_pkg::abs32(sm_x); mul_neg = sm_x[31];
      end
      S_FLX3:   begin
        mul_a = fpv_pkg::ALPHA_Q; mul_b = fpv_pkg::abs32(vec_y); mul_neg = vec_y[31];
      end
      S_FLY2:   begin
        mul_a = fpv_pkg::BETA_Q; mul_b = fpv_pkg::abs32(sm_y); mul_neg = sm_y[31];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      t_en       <= 1'b0;
      own_ofs_x  <= '0;
      own_ofs_y  <= '0;
      peer_ofs_x <= '0;
      peer_ofs_y <= '0;
      speed      <= 31'd6554;
      sm_x       <= '0;
      sm_y       <= '0;
      out_valid  <= 1'b0;
      sq_start   <= 1'b0;
      dv_start   <= 1'b0;
      pass       <= 1'b0;
      res_ok     <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_ENABLE:     t_en       <= pwdata[0];
          REG_OWN_OFS_X:  own_ofs_x  <= pwdata;
          REG_OWN_OFS_Y:  own_ofs_y  <= pwdata;
          REG_PEER_OFS_X: peer_ofs_x <= pwdata;
          REG_PEER_OFS_Y: peer_ofs_y <= pwdata;
          REG_SPEED:      speed      <= pwdata[30:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            inp   <= in_data;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!t_en || !inp.peer_present || (inp.peer_age_ms > fpv_pkg::STALE_LIMIT_MS))
          begin
            res_ok <= 1'b0;
            state  <= S_OUT;
          end else begin
            ex  <= fpv_pkg::sat32(66'(inp.peer_x) + 66'(own_ofs_x) - 66'(peer_ofs_x)
                                  - 66'(inp.own_x));
            ey  <= fpv_pkg::sat32(66'(inp.peer_y) + 66'(own_ofs_y) - 66'(peer_ofs_y)
                                  - 66'(inp.own_y));
            dvx <= fpv_pkg::sat32(66'(inp.peer_vx) - 66'(inp.own_vx));
            dvy <= fpv_pkg::sat32(66'(inp.peer_vy) - 66'(inp.own_vy));
            sq_start <= 1'b1;
            sq_arg   <= 64'(inp.position_variance) << fpv_pkg::FRAC_BITS;
            pass     <= 1'b0;
            state    <= S_UNC;
          end
        end
        S_UNC: begin
          if (sq_done) begin
            unc   <= sq_root;
            state <= S_KP_ISS;
          end
        end
        S_KP_ISS: begin
          factor <= factor_c;
          lim2   <= 32'(speed) + 32'(prod[63:34]);
          state  <= S_KP;
        end
        S_KP: begin
          kp    <= 32'((prod[63:0] + 64'(fpv_pkg::Q_HALF)) >> fpv_pkg::FRAC_BITS);
          state <= S_KD;
        end
        S_KD: begin
          kd    <= 32'((prod[63:0] + 64'(fpv_pkg::Q_HALF)) >> fpv_pkg::FRAC_BITS);
          state <= S_PX;
        end
        S_PX: begin
          acc   <= fpv_pkg::rnd(66'(prod));
          state <= S_DX;
        end
        S_DX: begin
          vec_x <= fpv_pkg::sat32(acc + fpv_pkg::rnd(66'(prod)));
          state <= S_PY;
        end
        S_PY: begin
          acc   <= fpv_pkg::rnd(66'(prod));
          state <= S_DY;
        end
        S_DY: begin
          vec_y <= fpv_pkg::sat32(acc + fpv_pkg::rnd(66'(prod)));
          state <= S_EX2;
        end
        S_EX2: begin
          acc   <= 66'(prod);
          state <= S_EY2;
        end
        S_EY2: begin
          if ((acc[63:0] + prod[63:0]) < fpv_pkg::DB_SQ) begin
            state <= S_CUTX;
          end else begin
            state <= S_LSQ;
          end
        end
        S_CUTX: begin
          vec_x <= fpv_pkg::sat32(fpv_pkg::rnd(66'(prod)));
          state <= S_CUTY;
        end
        S_CUTY: begin
          vec_y <= fpv_pkg::sat32(fpv_pkg::rnd(66'(prod)));
          state <= S_LSQ;
        end
        S_LSQ: begin
          state <= S_LSQX;
        end
        S_LSQX: begin
          acc   <= 66'(prod);
          state <= S_LSQY;
        end
        S_LSQY: begin
          sumsq <= acc[63:0] + prod[63:0];
          state <= S_LCMP;
        end
        S_LCMP: begin
          if (sumsq <= prod[63:0]) begin
            state <= S_LEND;
          end else begin
            sq_start <= 1'b1;
            sq_arg   <= sumsq;
            state    <= S_LSQRT;
          end
        end
        S_LSQRT: begin
          if (sq_done) begin
            mroot <= sq_root;
            state <= S_LMX;
          end
        end
        S_LMX: begin
          state <= S_LDX;
        end
        S_LDX: begin
          dv_start <= 1'b1;
          dv_num   <= prod[63:0] + 64'(mroot >> 1);
          dv_den   <= mroot;
          state    <= S_LWX;
        end
        S_LWX: begin
          if (dv_done) begin
            vec_x <= vec_x[31] ? 32'(-dv_quot) : dv_quot;
            state <= S_LMY;
          end
        end
        S_LMY: begin
          state <= S_LDY;
        end
        S_LDY: begin
          dv_start <= 1'b1;
          dv_num   <= prod[63:0] + 64'(mroot >> 1);
          dv_den   <= mroot;
          state    <= S_LWY;
        end
        S_LWY: begin
          if (dv_done) begin
            vec_y <= vec_y[31] ? 32'(-dv_quot) : dv_quot;
            state <= S_LEND;
          end
        end
        S_LEND: begin
          if (!pass) begin
            // Feedforward of the neighbour velocity, then the second limit.
            vec_x <= fpv_pkg::sat32(66'(inp.peer_vx) + 66'(vec_x));
            vec_y <= fpv_pkg::sat32(66'(inp.peer_vy) + 66'(vec_y));
            pass  <= 1'b1;
            state <= S_LSQ;
          end else begin
            state <= S_FLX;
          end
        end
        S_FLX: begin
          state <= S_FLX2;
        end
        S_FLX2: begin
          acc   <= 66'(prod);
          state <= S_FLX3;
        end
        S_FLX3: begin
          sm_x  <= fpv_pkg::sat32(fpv_pkg::rnd(acc + 66'(prod)));
          state <= S_FLY2;
        end
        S_FLY2: begin
          acc   <= 66'(prod);
          state <= S_FLY3;
        end
        S_FLY3: begin
          sm_y   <= fpv_pkg::sat32(fpv_pkg::rnd(acc + 66'(prod)));
          res_ok <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.cmd_vx    <= res_ok ? sm_x : 32'sd0;
            out_data.cmd_vy    <= res_ok ? sm_y : 32'sd0;
            out_data.cmd_valid <= res_ok;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.cmd_valid |-> out_data.cmd_vx == 0 && out_data.cmd_vy == 0)
    else $error("invalid command carries non-zero velocity");

  a_sqrt_owner: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_UNC || state == S_LSQRT))
    else $error("square root finished outside a waiting state");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_LWX || state == S_LWY))
    else $error("division finished outside a waiting state");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

endmodule

/* hw/rtl/fpv_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_mul: shared registered multiplier
// Unsigned 32 x 32 product with the sign applied, registered.
// ----------------------------------------------------------------------------
module fpv_mul (
  input  logic               clk,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic               neg,
  output logic signed [64:0] prod
);

  logic [63:0] p;

  assign p = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    prod <= neg ? -$signed({1'b0, p}) : $signed({1'b0, p});
  end

endmodule

/* hw/rtl/fpv_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module fpv_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] nreg;
  logic [33:0] rem;
  logic [35:0] r2;
  logic [35:0] trial;

  assign r2    = {rem, nreg[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nreg <= arg;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        nreg <= {nreg[61:0], 2'b00};
        if (r2 >= trial) begin
          rem  <= 34'(r2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= 34'(r2);
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/fpv_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_div: iterative restoring divider
// 64 by 32 bit division whose quotient fits 32 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module fpv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dreg;
  logic [32:0] r2;

  // The caller guarantees the upper half is below the divisor.
  assign r2 = {rem, quot[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num[63:32];
        quot <= num[31:0];
        dreg <= den;
      end else if (busy) begin
        if (r2 >= {1'b0, dreg}) begin
          rem  <= 32'(r2 - {1'b0, dreg});
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= r2[31:0];
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* verif/tb_formation_follow_pd_velocity.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_formation_follow_pd_velocity: self-checking bench for the follower
// Drives requests and register writes, predicts each command from an
// independent fixed-point model and compares every returned command in order.
// ----------------------------------------------------------------------------
module tb_formation_follow_pd_velocity;

  localparam logic [4:0] A_ENABLE   = 5'd0;
  localparam logic [4:0] A_OWN_OX   = 5'd4;
  localparam logic [4:0] A_OWN_OY   = 5'd8;
  localparam logic [4:0] A_PEER_OX  = 5'd12;
  localparam logic [4:0] A_PEER_OY  = 5'd16;
  localparam logic [4:0] A_SPEED    = 5'd20;
  localparam int LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fpv_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fpv_pkg::out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  formation_follow_pd_velocity dut (.*);

  // Command predictor: holds its own copy of registers and filter state.
  class follower_scoreboard;
    bit enable;
    longint own_ox, own_oy, peer_ox, peer_oy;
    longint unsigned speed;
    longint filt_x, filt_y;
    fpv_pkg::out_t pending[$];
    int errors;

    function void clear();
      enable = 0; own_ox = 0; own_oy = 0; peer_ox = 0; peer_oy = 0;
      speed = 6554; filt_x = 0; filt_y = 0; errors = 0;
    endfunction

    function void write_reg(logic [4:0] a, logic [31:0] d);
      case (a)
        A_ENABLE:  enable = d[0];
        A_OWN_OX:  own_ox = longint'($signed(d));
        A_OWN_OY:  own_oy = longint'($signed(d));
        A_PEER_OX: peer_ox = longint'($signed(d));
        A_PEER_OY: peer_oy = longint'($signed(d));
        A_SPEED:   speed = {33'd0, d[30:0]};
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint shr_round(longint v);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (fpv_pkg::FRAC_BITS - 1))) >> fpv_pkg::FRAC_BITS;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void clamp_mag(ref longint x, ref longint y, input longint unsigned lim);
      longint unsigned ax, ay, m;
      ax = mag(x); ay = mag(y);
      if (ax * ax + ay * ay <= lim * lim) return;
      m = root(ax * ax + ay * ay);
      ax = (ax * lim + m / 2) / m;
      ay = (ay * lim + m / 2) / m;
      x = x < 0 ? -longint'(ax) : longint'(ax);
      y = y < 0 ? -longint'(ay) : longint'(ay);
    endfunction

    function void note_request(fpv_pkg::in_t r);
      fpv_pkg::out_t e;
      longint ex, ey, cx, cy, vx, vy;
      longint unsigned unc, fac, kp, kd, d, esq;
      e = '0;
      if (enable && r.peer_present && r.peer_age_ms <= fpv_pkg::STALE_LIMIT_MS) begin
        ex = clip(longint'(r.peer_x) + (own_ox - peer_ox) - longint'(r.own_x));
        ey = clip(longint'(r.peer_y) + (own_oy - peer_oy) - longint'(r.own_y));
        unc = root({32'd0, r.position_variance} << fpv_pkg::FRAC_BITS);
        if (unc > fpv_pkg::UNC_HI_Q) begin
          fac = fpv_pkg::Q_HALF;
        end else if (unc > fpv_pkg::UNC_LO_Q) begin
          d = 5 * (unc - fpv_pkg::UNC_LO_Q);
          fac = d >= fpv_pkg::Q_ONE - fpv_pkg::Q_HALF ? fpv_pkg::Q_HALF :
                fpv_pkg::Q_ONE - d;
        end else begin
          fac = fpv_pkg::Q_ONE;
        end
        kp = (fpv_pkg::KP_Q * fac + fpv_pkg::Q_HALF) >> fpv_pkg::FRAC_BITS;
        kd = (fpv_pkg::KD_Q * fac + fpv_pkg::Q_HALF) >> fpv_pkg::FRAC_BITS;
        cx = clip(shr_round(longint'(kp) * ex) + shr_round(longint'(kd) *
             clip(longint'(r.peer_vx) - longint'(r.own_vx))));
        cy = clip(shr_round(longint'(kp) * ey) + shr_round(longint'(kd) *
             clip(longint'(r.peer_vy) - longint'(r.own_vy))));
        esq = mag(ex) * mag(ex) + mag(ey) * mag(ey);
        if (esq < fpv_pkg::DB_SQ) begin
          cx = shr_round(longint'(fpv_pkg::CUT_Q) * cx);
          cy = shr_round(longint'(fpv_pkg::CUT_Q) * cy);
        end
        clamp_mag(cx, cy, (3 * speed + 1) / 2);
        vx = clip(longint'(r.peer_vx) + cx);
        vy = clip(longint'(r.peer_vy) + cy);
        clamp_mag(vx, vy, (6 * speed + 2) / 5);
        filt_x = clip(shr_round(longint'(fpv_pkg::ALPHA_Q) * vx +
                                longint'(fpv_pkg::BETA_Q) * filt_x));
        filt_y = clip(shr_round(longint'(fpv_pkg::ALPHA_Q) * vy +
                                longint'(fpv_pkg::BETA_Q) * filt_y));
        e.cmd_vx = filt_x[31:0];
        e.cmd_vy = filt_y[31:0];
        e.cmd_valid = 1'b1;
      end
      pending.push_back(e);
    endfunction

    function void check_command(fpv_pkg::out_t got);
      fpv_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cmd_vx !== e.cmd_vx) begin
        $display("%0t: cmd_vx expected %0d actual %0d", $time, e.cmd_vx, got.cmd_vx);
        errors++;
      end
      if (got.cmd_vy !== e.cmd_vy) begin
        $display("%0t: cmd_vy expected %0d actual %0d", $time, e.cmd_vy, got.cmd_vy);
        errors++;
      end
      if (got.cmd_valid !== e.cmd_valid) begin
        $display("%0t: cmd_valid expected %0d actual %0d", $time, e.cmd_valid,
                 got.cmd_valid);
        errors++;
      end
    endfunction
  endclass

  follower_scoreboard sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_formation_follow_pd_velocity NOT OK");
      $finish;
    end
  end

  // Receiver side: random stalls, commands checked on acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_command(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Registers are only written once every outstanding command has returned.
  task automatic write_reg(logic [4:0] a, logic [31:0] d);
    while (sb.pending.size() != 0) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(a, d);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send(fpv_pkg::in_t r);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(20000)) - 10000);
      3: return 32'(int'($urandom_range(400000)) - 200000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int spread);
    return base + 32'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  // Mostly plausible ticks near the formation target, some wild noise.
  function automatic fpv_pkg::in_t rand_request();
    fpv_pkg::in_t r;
    int span;
    span = ($urandom_range(3) == 0) ? 1500 : 80000;
    if ($urandom_range(9) < 8) begin
      r.own_x = $urandom_range(1000000) - 500000;
      r.own_y = $urandom_range(1000000) - 500000;
      r.peer_x = near(r.own_x - 32'(sb.own_ox - sb.peer_ox), span);
      r.peer_y = near(r.own_y - 32'(sb.own_oy - sb.peer_oy), span);
      r.own_vx = near(0, 20000); r.own_vy = near(0, 20000);
      r.peer_vx = near(0, 20000); r.peer_vy = near(0, 20000);
      r.position_variance = $urandom_range(4000);
      r.peer_present = ($urandom_range(19) != 0);
      r.peer_age_ms = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1010));
    end else begin
      r.own_x = pick32(); r.own_y = pick32(); r.own_vx = pick32(); r.own_vy = pick32();
      r.peer_x = pick32(); r.peer_y = pick32(); r.peer_vx = pick32(); r.peer_vy = pick32();
      r.position_variance = $urandom();
      r.peer_present = 1'($urandom_range(1));
      r.peer_age_ms = 16'($urandom());
    end
    return r;
  endfunction

  task automatic set_formation(logic en, logic [31:0] spd);
    write_reg(A_ENABLE, {31'd0, en});
    write_reg(A_OWN_OX, pick32());
    write_reg(A_OWN_OY, pick32());
    write_reg(A_PEER_OX, pick32());
    write_reg(A_PEER_OY, pick32());
    write_reg(A_SPEED, spd);
  endtask

  initial begin
    fpv_pkg::in_t r;
    sb.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: inactive, missing and stale neighbour, extremes, deadband.
    r = '0;
    r.peer_present = 1'b1;
    send(r);
    write_reg(A_ENABLE, 32'd1);
    send(r);
    r.peer_present = 1'b0; send(r);
    r.peer_present = 1'b1; r.peer_age_ms = 16'd1000; send(r);
    r.peer_age_ms = 16'd1001; send(r);
    r.peer_age_ms = 16'hffff; send(r);
    r.peer_age_ms = 16'd0;
    r.peer_x = 32'd1000; send(r);
    r.peer_x = 32'd1400; r.peer_vx = 32'd3000; send(r);
    r.position_variance = 32'd655; send(r);
    r.position_variance = 32'd1500; send(r);
    r.position_variance = 32'd2621; send(r);
    r.position_variance = 32'hffffffff; send(r);
    r = '1; r.peer_age_ms = 16'd0; send(r);
    r.own_x = 32'h80000000; r.peer_x = 32'h7fffffff; r.own_y = 32'h7fffffff;
    r.peer_y = 32'h80000000; r.own_vx = 32'h80000000; r.peer_vx = 32'h7fffffff;
    r.own_vy = 32'h7fffffff; r.peer_vy = 32'h80000000; send(r);
    drain();
    write_reg(A_SPEED, 32'd0);
    send(r);
    r.peer_x = 32'd70000; r.own_x = 0; send(r);
    drain();
    write_reg(A_SPEED, 32'h7fffffff);
    write_reg(A_OWN_OX, 32'h7fffffff);
    write_reg(A_PEER_OX, 32'h80000000);
    write_reg(A_OWN_OY, 32'h80000000);
    write_reg(A_PEER_OY, 32'h7fffffff);
    send(r);
    r = '0; r.peer_present = 1'b1; send(r);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: begin send_idle = 31; recv_idle = 74; end
        1: begin send_idle = 74; recv_idle = 31; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      set_formation(ph != 5, (ph == 3) ? 32'h7fffffff : (ph == 6) ? 32'd0 :
                    32'($urandom_range(200000)));
      for (int i = 0; i < 200; i++) begin
        send(rand_request());
        if (i == 100) begin
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_formation_follow_pd_velocity OK");
    end else begin
      $display("tb_formation_follow_pd_velocity NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fpv_pkg.sv
hw/rtl/fpv_mul.sv
hw/rtl/fpv_sqrt.sv
hw/rtl/fpv_div.sv
hw/rtl/formation_follow_pd_velocity.sv
verif/tb_formation_follow_pd_velocity.sv
